// File: hw/rtl/sapd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types and constants for the serial packet decoder.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // result kinds
    localparam logic [3:0] KIND_MOTION  = 4'd0;
    localparam logic [3:0] KIND_CSUMBAD = 4'd1;
    localparam logic [3:0] KIND_BUTTONS = 4'd2;
    localparam logic [3:0] KIND_NULL    = 4'd3;
    localparam logic [3:0] KIND_SENS    = 4'd4;
    localparam logic [3:0] KIND_PULSE   = 4'd5;
    localparam logic [3:0] KIND_ERROR   = 4'd6;
    localparam logic [3:0] KIND_INFO    = 4'd7;
    localparam logic [3:0] KIND_UNKNOWN = 4'd8;

    // snapshot of the first fifteen stored bytes of a packet (zero past end)
    localparam int SNAP_BYTES = 15;

    typedef struct packed {
        logic [SNAP_BYTES-1:0][7:0] bytes;
        logic [SNAP_BYTES-1:0]      present;
        logic                       dev1;
    } sapd_packet_t;

    // descramble key, applied to byte j with key[j-1]
    function automatic logic [7:0] sapd_key(input logic [3:0] idx);
        logic [7:0] k;
        begin
            case (idx)
                4'd1:    k = 8'h53;
                4'd2:    k = 8'h70;
                4'd3:    k = 8'h61;
                4'd4:    k = 8'h63;
                4'd5:    k = 8'h65;
                4'd6:    k = 8'h57;
                4'd7:    k = 8'h61;
                4'd8:    k = 8'h72;
                4'd9:    k = 8'h65;
                default: k = 8'h00;
            endcase
            return k;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sapd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_front
// Frames received bytes into packets and hands each finished packet on.
// ----------------------------------------------------------------------------
module sapd_front #(
    parameter int STORE_BYTES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  device_kind,
    output sapd_pkg::sapd_packet_t     pkt,
    output logic                       pkt_valid
);
    import sapd_pkg::*;

    localparam int IW = $clog2(STORE_BYTES);

    logic [STORE_BYTES-1:0][7:0] bytes_reg;
    logic [7:0]                  count_reg;
    logic [7:0]                  prev_reg;

    logic is_cr;
    logic drop_lf;
    logic store;
    assign is_cr   = (rx_byte == BYTE_CR);
    assign drop_lf = (rx_byte == BYTE_LF) && (prev_reg == BYTE_CR);
    assign store   = in_valid && !is_cr && !drop_lf;

    // finished packet snapshot
    always_comb
    begin
        pkt.dev1 = device_kind;
        for (int j = 0; j < SNAP_BYTES; j++)
        begin
            pkt.present[j] = (8'(j) < count_reg) && (j < STORE_BYTES);
            pkt.bytes[j]   = pkt.present[j] ? bytes_reg[j] : 8'h00;
        end
    end
    assign pkt_valid = in_valid && is_cr && (count_reg != 8'd0);

    // byte store, count and previous byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 8'd0;
            prev_reg  <= BYTE_CR;
        end
        else if (in_valid)
        begin
            prev_reg <= rx_byte;
            if (is_cr)
                count_reg <= 8'd0;
            else if (store && count_reg != 8'hFF)
                count_reg <= count_reg + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store && count_reg < 8'(STORE_BYTES))
            bytes_reg[count_reg[IW-1:0]] <= rx_byte;
    end
endmodule
`default_nettype wire

// File: hw/rtl/sapd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_queue
// Two-entry queue of packets between framing and decoding.
// ----------------------------------------------------------------------------
module sapd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  sapd_pkg::sapd_packet_t  wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output sapd_pkg::sapd_packet_t  rd_data,
    output logic                    rd_valid
);
    import sapd_pkg::*;

    sapd_packet_t mem_reg [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// File: hw/rtl/sapd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sapd_back
// Decodes a packet per cycle unless a held result waits; updates held values.
// ----------------------------------------------------------------------------
module sapd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  sapd_pkg::sapd_packet_t  pkt,
    input  wire logic               pkt_valid,
    output logic                    pkt_take,
    output logic                    empty,
    input  wire logic               pop,
    output logic [3:0]              packet_kind,
    output logic signed [14:0]      trans_x,
    output logic signed [14:0]      trans_y,
    output logic signed [14:0]      trans_z,
    output logic signed [14:0]      rot_x,
    output logic signed [14:0]      rot_y,
    output logic signed [14:0]      rot_z,
    output logic [15:0]             button_mask,
    output logic [11:0]             value_a,
    output logic [11:0]             value_b
);
    import sapd_pkg::*;

    // held state
    logic [5:0][15:0] axis_reg, axis_next;
    logic [15:0]      btn_reg, btn_next;
    logic [6:0]       null_reg, null_next;
    logic [5:0]       tsens_reg, tsens_next, rsens_reg, rsens_next;
    logic [11:0]      pmax_reg, pmax_next, pmin_reg, pmin_next;
    logic [7:0]       err_reg, err_next;

    // output register
    logic             full_reg;
    logic [3:0]       kind_reg;
    logic [5:0][14:0] oaxis_reg;
    logic [15:0]      obtn_reg;
    logic [11:0]      oa_reg, ob_reg;

    logic [3:0]  kind;
    logic [11:0] va, vb;
    logic [14:0][7:0] b;
    logic [10:0][7:0] r;
    logic [11:0] sum;
    logic        dev1;

    assign pkt_take = pkt_valid && (!full_reg || pop);

    function automatic logic [15:0] ten_scaled(input logic [9:0] raw, input logic neg);
        logic [15:0] v;
        begin
            v = {{5{raw[9]}}, raw, 1'b0};
            return neg ? (16'd0 - v) : v;
        end
    endfunction

    function automatic logic [15:0] twelve_scaled(input logic [7:0] hi, input logic [7:0] lo,
                                                  input logic neg);
        logic [15:0] v;
        begin
            v = {2'b00, hi[5:0], lo[5:0], 2'b00};
            return neg ? (16'd8192 - v) : (v - 16'd8192);
        end
    endfunction

    // packet decode
    always_comb
    begin
        b    = pkt.bytes;
        dev1 = pkt.dev1;
        r[0] = b[0];
        for (int j = 1; j <= 10; j++)
            r[j] = pkt.present[j] ? (b[j] ^ sapd_key(4'(j - 1))) : 8'h00;
        sum = '0;
        for (int j = 1; j <= 12; j++)
            sum = sum + {4'h0, b[j]};

        axis_next  = axis_reg;
        btn_next   = btn_reg;
        null_next  = null_reg;
        tsens_next = tsens_reg;
        rsens_next = rsens_reg;
        pmax_next  = pmax_reg;
        pmin_next  = pmin_reg;
        err_next   = err_reg;
        kind       = KIND_UNKNOWN;

        if (b[0] == "D" && !dev1)
        begin
            kind = KIND_MOTION;
            axis_next[0] = ten_scaled({r[2][6:0], r[3][6:4]}, 1'b0);
            axis_next[2] = ten_scaled({r[3][3:0], r[4][6:1]}, 1'b1);
            axis_next[1] = ten_scaled({r[4][0], r[5][6:0], r[6][6:5]}, 1'b1);
            axis_next[3] = ten_scaled({r[6][4:0], r[7][6:2]}, 1'b0);
            axis_next[5] = ten_scaled({r[7][1:0], r[8][6:0], r[9][6]}, 1'b1);
            axis_next[4] = ten_scaled({r[9][5:0], r[10][6:3]}, 1'b1);
        end
        else if (b[0] == "d" && dev1)
        begin
            if (sum != {b[13][5:0], b[14][5:0]})
                kind = KIND_CSUMBAD;
            else
            begin
                kind = KIND_MOTION;
                axis_next[0] = twelve_scaled(b[1], b[2], 1'b0);
                axis_next[1] = twelve_scaled(b[3], b[4], 1'b0);
                axis_next[2] = twelve_scaled(b[5], b[6], 1'b1);
                axis_next[3] = twelve_scaled(b[7], b[8], 1'b0);
                axis_next[4] = twelve_scaled(b[9], b[10], 1'b0);
                axis_next[5] = twelve_scaled(b[11], b[12], 1'b1);
            end
        end
        else if (b[0] == "K" && !dev1)
        begin
            kind = KIND_BUTTONS;
            btn_next = {3'b000, b[2][0], 1'b0, b[2][6:4], 4'h0, b[2][3:0]};
        end
        else if (b[0] == "k" && dev1)
        begin
            kind = KIND_BUTTONS;
            btn_next = {b[3][3:0], b[2][3:0], 4'h0, b[1][3:0]};
        end
        else if (b[0] == "R")
        begin
            kind = KIND_INFO;
            err_next = 8'h00;
        end
        else if (b[0] == "N")
        begin
            kind = KIND_NULL;
            null_next = {b[1][6] & !dev1, b[1][5:0]};
        end
        else if (b[0] == "n")
        begin
            kind = KIND_NULL;
            null_next = {1'b0, b[1][5:0]};
        end
        else if (b[0] == "F" && b[1] == "R")
        begin
            kind = KIND_SENS;
            rsens_next = b[2][5:0];
        end
        else if (b[0] == "F" && b[1] == "T")
        begin
            kind = KIND_SENS;
            tsens_next = b[2][5:0];
        end
        else if (b[0] == "q")
        begin
            kind = KIND_SENS;
            tsens_next = {2'b00, b[2][3:0]};
            rsens_next = {2'b00, b[3][3:0]};
        end
        else if (b[0] == "E")
        begin
            kind = KIND_ERROR;
            err_next = b[1];
        end
        else if (b[0] == "!" || b[0] == "$")
            kind = KIND_INFO;
        else if (b[0] == "P")
        begin
            kind = KIND_PULSE;
            if (!dev1)
            begin
                pmax_next = {5'd0, b[1][6:0]};
                pmin_next = {5'd0, b[2][6:0]};
            end
            else
            begin
                pmax_next = {b[1][5:0], b[2][5:0]};
                pmin_next = {b[3][5:0], b[4][5:0]};
            end
        end
        else if (b[0] == "p")
        begin
            kind = KIND_PULSE;
            pmax_next = {8'd0, b[1][3:0]};
            pmin_next = {8'd0, b[2][3:0]};
        end

        va = '0;
        vb = '0;
        case (kind)
            KIND_NULL:  va = {5'd0, null_next};
            KIND_SENS:
            begin
                va = {6'd0, tsens_next};
                vb = {6'd0, rsens_next};
            end
            KIND_PULSE:
            begin
                va = pmax_next;
                vb = pmin_next;
            end
            KIND_ERROR: va = {4'd0, err_next};
            default:    va = '0;
        endcase
    end

    // held registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= '0;
            btn_reg   <= '0;
            null_reg  <= '0;
            tsens_reg <= '0;
            rsens_reg <= '0;
            pmax_reg  <= '0;
            pmin_reg  <= '0;
            err_reg   <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (pkt_take)
            begin
                axis_reg  <= axis_next;
                btn_reg   <= btn_next;
                null_reg  <= null_next;
                tsens_reg <= tsens_next;
                rsens_reg <= rsens_next;
                pmax_reg  <= pmax_next;
                pmin_reg  <= pmin_next;
                err_reg   <= err_next;
                full_reg  <= 1'b1;
            end
            else if (pop)
                full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            kind_reg <= kind;
            for (int j = 0; j < 6; j++)
                oaxis_reg[j] <= axis_next[j][14:0];
            obtn_reg <= btn_next;
            oa_reg   <= va;
            ob_reg   <= vb;
        end
    end

    assign empty       = !full_reg;
    assign packet_kind = kind_reg;
    assign trans_x     = oaxis_reg[0];
    assign trans_y     = oaxis_reg[1];
    assign trans_z     = oaxis_reg[2];
    assign rot_x       = oaxis_reg[3];
    assign rot_y       = oaxis_reg[4];
    assign rot_z       = oaxis_reg[5];
    assign button_mask = obtn_reg;
    assign value_a     = oa_reg;
    assign value_b     = ob_reg;
endmodule
`default_nettype wire

// File: hw/rtl/six_axis_serial_packet_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// six_axis_serial_packet_decoder
// Frames serial bytes into packets and decodes six-axis controller packets.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low. A carriage return closes a packet;
// the packet is queued (two deep) and decoded combinationally by the back end
// into a result register. With the queue empty and the result register empty or
// being popped, the packet is written into the queue at the edge that transfers
// its carriage return and its result is on the ports from the next edge on. full
// rises only when both queue entries and the result register hold packets not yet popped.
module six_axis_serial_packet_decoder #(
    parameter int STORE_BYTES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_wdata,
    output logic                    empty,
    input  wire logic               pop,
    output logic [3:0]              packet_kind,
    output logic signed [14:0]      trans_x,
    output logic signed [14:0]      trans_y,
    output logic signed [14:0]      trans_z,
    output logic signed [14:0]      rot_x,
    output logic signed [14:0]      rot_y,
    output logic signed [14:0]      rot_z,
    output logic [15:0]             button_mask,
    output logic [11:0]             value_a,
    output logic [11:0]             value_b
);
    import sapd_pkg::*;

    logic         dev_reg;
    sapd_packet_t f_pkt, q_pkt;
    logic         f_valid, q_valid, q_take;

    // device kind register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_reg <= 1'b0;
        else if (cfg_we)
            dev_reg <= cfg_wdata[0];
    end

    sapd_front #(.STORE_BYTES(STORE_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(push && !full), .rx_byte(rx_byte),
        .device_kind(dev_reg), .pkt(f_pkt), .pkt_valid(f_valid)
    );

    sapd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_pkt), .full(full),
        .rd_en(q_take), .rd_data(q_pkt), .rd_valid(q_valid)
    );

    sapd_back u_back (
        .clk(clk), .rst_n(rst_n), .pkt(q_pkt), .pkt_valid(q_valid), .pkt_take(q_take),
        .empty(empty), .pop(pop), .packet_kind(packet_kind),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .button_mask(button_mask),
        .value_a(value_a), .value_b(value_b)
    );
endmodule
`default_nettype wire
